/* design/i2scrs_pkg.sv */
// Shared constants and lookup functions for the I2S clock ratio search unit.
// Holds the master clock table, the supported ratio list and field widths.
// No dependencies.
package i2scrs_pkg;

    localparam int CLOCK_ENTRIES = 18;
    localparam int TABLE_SIZE    = 18;
    localparam int ENTRY_COUNT   = (CLOCK_ENTRIES > TABLE_SIZE) ? TABLE_SIZE :
                                   ((CLOCK_ENTRIES < 1) ? 1 : CLOCK_ENTRIES);

    localparam int DATA_W   = 24;
    localparam int IDX_W    = 5;
    localparam int CODE_W   = 4;
    localparam int WIDTH_W  = 2;
    localparam int GRAN_W   = 6;
    localparam int LIST_SIZE = 9;

    localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(ENTRY_COUNT - 1);
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 2'd2;

    // output word layout, lowest bit first
    localparam int OUT_BITS = IDX_W + DATA_W + DATA_W + CODE_W + 1 + DATA_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [DATA_W-1:0] t_data;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              found;
    } t_ratio_lookup;

    function automatic t_data mclk_rom(input logic [IDX_W-1:0] idx);
        t_data freq;
        case (idx)
            5'd0:    freq = 24'd256000;
            5'd1:    freq = 24'd507937;
            5'd2:    freq = 24'd761905;
            5'd3:    freq = 24'd1000000;
            5'd4:    freq = 24'd1032258;
            5'd5:    freq = 24'd1066667;
            5'd6:    freq = 24'd1391304;
            5'd7:    freq = 24'd1523810;
            5'd8:    freq = 24'd2000000;
            5'd9:    freq = 24'd2133333;
            5'd10:   freq = 24'd2909091;
            5'd11:   freq = 24'd3200000;
            5'd12:   freq = 24'd4000000;
            5'd13:   freq = 24'd5333333;
            5'd14:   freq = 24'd6400000;
            5'd15:   freq = 24'd8000000;
            5'd16:   freq = 24'd10666667;
            5'd17:   freq = 24'd16000000;
            default: freq = 24'd256000;
        endcase
        return freq;
    endfunction

    function automatic t_data ratio_list(input int i);
        t_data r;
        case (i)
            0:       r = 24'd32;
            1:       r = 24'd48;
            2:       r = 24'd64;
            3:       r = 24'd96;
            4:       r = 24'd128;
            5:       r = 24'd192;
            6:       r = 24'd256;
            7:       r = 24'd384;
            default: r = 24'd512;
        endcase
        return r;
    endfunction

    // first match wins; not found gives code zero
    function automatic t_ratio_lookup lookup_ratio(input t_data ratio);
        t_ratio_lookup res;
        res.code  = '0;
        res.found = 1'b0;
        for (int i = LIST_SIZE - 1; i >= 0; i--) begin
            if (ratio == ratio_list(i)) begin
                res.code  = CODE_W'(i);
                res.found = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

/* design/i2scrs_div.sv */
// Shared restoring divider, one quotient bit per clock.
// Uses i2scrs_pkg for the operand width.
module i2scrs_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  i2scrs_pkg::t_data    i_num,
    input  i2scrs_pkg::t_data    i_den,
    output logic                 o_done,
    output i2scrs_pkg::t_data    o_quot
);

    localparam int CNT_W = $clog2(i2scrs_pkg::DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(i2scrs_pkg::DATA_W - 1);

    i2scrs_pkg::t_data r_num, r_den, r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy, r_done;

    logic [i2scrs_pkg::DATA_W:0] w_trial;
    logic                        w_ge;

    assign w_trial = {r_rem, r_num[i2scrs_pkg::DATA_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            // shift quotient bits in where numerator bits leave
            r_num <= {r_num[i2scrs_pkg::DATA_W-2:0], w_ge};
            r_rem <= w_ge ? i2scrs_pkg::DATA_W'(w_trial - {1'b0, r_den})
                          : w_trial[i2scrs_pkg::DATA_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

/* design/i2s_clock_ratio_search_unit.sv */
// Top level of the I2S clock ratio search unit: sequencer around one divider.
// Depends on i2scrs_pkg and i2scrs_div.
//
// For each requested sample rate the unit walks the master clock table, forms
// the rounded clock ratio and the achieved rate for every entry, and returns
// the entry with the smallest rate error (lowest index on a tie). The
// divisions of an entry, two when the raw ratio is at or below the granule
// and three otherwise, share one 24-bit restoring divider. The input is not
// ready during the search; a new word is taken while the previous result
// still waits at the output.
module i2s_clock_ratio_search_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [i2scrs_pkg::WIDTH_W-1:0]      i_cfg_wr_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [23:0] target_rate
    input  logic [i2scrs_pkg::DATA_W-1:0]       i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [4:0] clock_index, [28:5] master_clock_hz, [52:29] clock_ratio,
    // [56:53] ratio_code, [57] ratio_found, [81:58] achieved_rate, rest zero
    output logic [i2scrs_pkg::OUT_W-1:0]        o_m_tdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_D1   = 3'd1;
    localparam logic [2:0] S_D2   = 3'd2;
    localparam logic [2:0] S_D3   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                         r_state, n_state;
    logic [i2scrs_pkg::WIDTH_W-1:0]     r_width;
    logic [i2scrs_pkg::WIDTH_W-1:0]     r_w;
    i2scrs_pkg::t_data                  r_rate;
    logic [i2scrs_pkg::IDX_W-1:0]       r_idx;
    i2scrs_pkg::t_data                  r_best_err, r_best_ratio, r_best_rate;
    logic [i2scrs_pkg::IDX_W-1:0]       r_best_idx;
    i2scrs_pkg::t_data                  r_ratio, n_ratio;
    logic                               r_out_valid;
    logic [i2scrs_pkg::OUT_W-1:0]       r_out;

    logic                               w_accept;
    logic                               w_div_start, w_div_done;
    i2scrs_pkg::t_data                  w_div_num, w_div_den, w_quot;
    logic [i2scrs_pkg::GRAN_W-1:0]      w_gran;
    i2scrs_pkg::t_data                  w_gran_ext, w_round_num, w_rounded;
    logic [i2scrs_pkg::DATA_W+i2scrs_pkg::WIDTH_W-1:0] w_qw;
    i2scrs_pkg::t_data                  w_err, w_in_rate;
    logic [i2scrs_pkg::WIDTH_W-1:0]     w_in_width;
    logic                               w_better;
    i2scrs_pkg::t_ratio_lookup          w_lookup;
    logic                               w_out_free;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_m_tready;

    // zero rate and zero width behave as one
    assign w_in_rate  = (i_s_tdata == '0) ? i2scrs_pkg::DATA_W'(1) : i_s_tdata;
    assign w_in_width = (r_width == '0) ? i2scrs_pkg::WIDTH_W'(1) : r_width;

    assign w_gran      = {r_w, 4'b0000};
    assign w_gran_ext  = i2scrs_pkg::DATA_W'(w_gran);
    assign w_round_num = w_quot + i2scrs_pkg::DATA_W'(w_gran[i2scrs_pkg::GRAN_W-1:1]);
    assign w_qw        = w_quot * r_w;
    assign w_rounded   = i2scrs_pkg::DATA_W'({w_qw, 4'b0000});

    assign w_err    = (w_quot > r_rate) ? (w_quot - r_rate) : (r_rate - w_quot);
    assign w_better = (r_idx == '0) || (w_err < r_best_err);
    assign w_lookup = i2scrs_pkg::lookup_ratio(r_best_ratio);

    i2scrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_ratio     = r_ratio;
        w_div_start = 1'b0;
        w_div_num   = i2scrs_pkg::mclk_rom(r_idx);
        w_div_den   = r_rate;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_div_start = 1'b1;
                    w_div_num   = i2scrs_pkg::mclk_rom('0);
                    w_div_den   = w_in_rate;
                    n_state     = S_D1;
                end
            end
            S_D1: begin
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    if (w_quot > w_gran_ext) begin
                        w_div_num = w_round_num;
                        w_div_den = w_gran_ext;
                        n_state   = S_D2;
                    end else begin
                        n_ratio   = w_gran_ext;
                        w_div_den = w_gran_ext;
                        n_state   = S_D3;
                    end
                end
            end
            S_D2: begin
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    n_ratio     = w_rounded;
                    w_div_den   = w_rounded;
                    n_state     = S_D3;
                end
            end
            S_D3: begin
                if (w_div_done) begin
                    if (r_idx == i2scrs_pkg::LAST_IDX) begin
                        n_state = S_FIN;
                    end else begin
                        w_div_start = 1'b1;
                        w_div_num   = i2scrs_pkg::mclk_rom(r_idx + 1'b1);
                        n_state     = S_D1;
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= i2scrs_pkg::WIDTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_width <= i_cfg_wr_data;
            end
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ratio <= n_ratio;
        if (w_accept) begin
            r_rate <= w_in_rate;
            r_w    <= w_in_width;
            r_idx  <= '0;
        end
        if (r_state == S_D3 && w_div_done) begin
            if (w_better) begin
                r_best_err   <= w_err;
                r_best_idx   <= r_idx;
                r_best_ratio <= r_ratio;
                r_best_rate  <= w_quot;
            end
            r_idx <= r_idx + 1'b1;
        end
        if (r_state == S_FIN && w_out_free) begin
            r_out <= i2scrs_pkg::OUT_W'({r_best_rate, w_lookup.found, w_lookup.code,
                                        r_best_ratio, i2scrs_pkg::mclk_rom(r_best_idx),
                                        r_best_idx});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

/* design/i2scrs_checker.sv */
// Port-level checks for the I2S clock ratio search unit, bound to the top level.
// Depends on i2scrs_pkg and i2s_clock_ratio_search_unit.
module i2scrs_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                o_s_tready,
    input  logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [i2scrs_pkg::OUT_W-1:0]        o_m_tdata
);

    // an output word is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("output word dropped while stalled");

    // the search keeps the input not ready, so no second word right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after accept");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[4:0] <= i2scrs_pkg::LAST_IDX))
        else $error("clock index beyond table");

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[57]) |-> (o_m_tdata[56:53] == 4'd0))
        else $error("ratio code set without a match");

    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[57]) |->
            (o_m_tdata[52:29] >= 24'd32 && o_m_tdata[52:29] <= 24'd512))
        else $error("matched ratio outside list range");

endmodule

bind i2s_clock_ratio_search_unit i2scrs_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

/* tb/sv/testbench.sv */
// Testbench for i2s_clock_ratio_search_unit: drives target rates, predicts the
// best master clock entry, ratio and achieved rate, and checks every result word.
// Depends on i2scrs_pkg and the i2s_clock_ratio_search_unit RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 20000;
    localparam int SETTLE_TICKS = 1400;
    localparam int PAD_W        = i2scrs_pkg::OUT_W - i2scrs_pkg::OUT_BITS;

    // same layout as o_m_tdata, lowest field last
    typedef struct packed {
        logic [PAD_W-1:0]              pad;
        logic [i2scrs_pkg::DATA_W-1:0] achieved;
        logic                          found;
        logic [i2scrs_pkg::CODE_W-1:0] code;
        logic [i2scrs_pkg::DATA_W-1:0] ratio;
        logic [i2scrs_pkg::DATA_W-1:0] mclk;
        logic [i2scrs_pkg::IDX_W-1:0]  idx;
    } t_clock_choice;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_wr_en   = 1'b0;
    logic [i2scrs_pkg::WIDTH_W-1:0] i_cfg_wr_data = '0;
    logic                           i_s_tvalid    = 1'b0;
    logic [i2scrs_pkg::DATA_W-1:0]  i_s_tdata     = '0;
    logic                           i_m_tready    = 1'b0;
    wire                            o_s_tready;
    wire                            o_m_tvalid;
    wire [i2scrs_pkg::OUT_W-1:0]    o_m_tdata;

    int unsigned mclk_freqs [18] = '{
        256000, 507937, 761905, 1000000, 1032258, 1066667,
        1391304, 1523810, 2000000, 2133333, 2909091, 3200000,
        4000000, 5333333, 6400000, 8000000, 10666667, 16000000
    };
    int unsigned listed_ratios [9] = '{32, 48, 64, 96, 128, 192, 256, 384, 512};

    logic [i2scrs_pkg::WIDTH_W-1:0] width_setting = 2'd2;
    t_clock_choice      pending_choices [$];
    int                 rates_sent      = 0;
    int                 choices_checked = 0;
    int                 mismatches      = 0;
    int                 quiet_cycles    = 0;
    int                 tx_idle_pct     = 0;
    int                 rx_idle_pct     = 0;
    int                 rx_hold_cycles  = 0;

    i2s_clock_ratio_search_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_clock_choice pick_best_clock(
        input logic [i2scrs_pkg::DATA_W-1:0]  rate_word,
        input logic [i2scrs_pkg::WIDTH_W-1:0] width);
        t_clock_choice choice;
        int unsigned   rate;
        int unsigned   gran;
        int unsigned   ratio;
        int unsigned   got;
        int unsigned   err;
        int unsigned   best_err;
        int unsigned   best_idx;
        int unsigned   best_ratio;
        int unsigned   best_got;
        rate       = (rate_word == '0) ? 1 : rate_word;
        gran       = ((width == '0) ? 1 : width) * 16;
        best_err   = 0;
        best_idx   = 0;
        best_ratio = 0;
        best_got   = 0;
        for (int i = 0; i < i2scrs_pkg::ENTRY_COUNT; i++) begin
            ratio = mclk_freqs[i] / rate;
            // round to the nearest granule, halves up; clamp small ratios to one granule
            if (ratio > gran) begin
                ratio = ((ratio + gran / 2) / gran) * gran;
            end else begin
                ratio = gran;
            end
            got = mclk_freqs[i] / ratio;
            err = (got > rate) ? got - rate : rate - got;
            // strict compare keeps the lowest index on a tie
            if (i == 0 || err < best_err) begin
                best_err   = err;
                best_idx   = i;
                best_ratio = ratio;
                best_got   = got;
            end
        end
        choice          = '0;
        choice.idx      = i2scrs_pkg::IDX_W'(best_idx);
        choice.mclk     = i2scrs_pkg::DATA_W'(mclk_freqs[best_idx]);
        choice.ratio    = i2scrs_pkg::DATA_W'(best_ratio);
        choice.achieved = i2scrs_pkg::DATA_W'(best_got);
        for (int k = 8; k >= 0; k--) begin
            if (listed_ratios[k] == best_ratio) begin
                choice.code  = i2scrs_pkg::CODE_W'(k);
                choice.found = 1'b1;
            end
        end
        return choice;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned seen);
        if (want != seen) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
        end
    endtask

    // predict on each accepted rate word, check each accepted result word
    always @(posedge i_clk) begin : monitor
        t_clock_choice want;
        t_clock_choice seen;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            pending_choices.push_back(pick_best_clock(i_s_tdata, width_setting));
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen = o_m_tdata;
            choices_checked++;
            if (pending_choices.size() == 0) begin
                mismatches++;
                $display("%0t: result word expected none actual %h", $time, o_m_tdata);
            end else begin
                want = pending_choices.pop_front();
                check_field("clock_index", want.idx, seen.idx);
                check_field("master_clock_hz", want.mclk, seen.mclk);
                check_field("clock_ratio", want.ratio, seen.ratio);
                check_field("ratio_code", want.code, seen.code);
                check_field("ratio_found", want.found, seen.found);
                check_field("achieved_rate", want.achieved, seen.achieved);
                check_field("padding", want.pad, seen.pad);
            end
        end
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_wr_en) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("i2s_clock_ratio_search_unit test failed");
            $finish;
        end
    end

    // result side: random stalls, or one long hold-off when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles != 0) begin
                i_m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [i2scrs_pkg::DATA_W-1:0] random_rate();
        case ($urandom_range(9)) inside
            0:       return i2scrs_pkg::DATA_W'($urandom());
            [1:2]:   return i2scrs_pkg::DATA_W'($urandom_range(4000, 1));
            [3:7]:   return i2scrs_pkg::DATA_W'($urandom_range(200000, 4000));
            default: return i2scrs_pkg::DATA_W'($urandom_range(16000000, 200000));
        endcase
    endfunction

    task automatic send_rate(input logic [i2scrs_pkg::DATA_W-1:0] rate);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rate;
        do @(posedge i_clk); while (!o_s_tready);
        rates_sent++;
    endtask

    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        while (choices_checked < rates_sent) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [i2scrs_pkg::WIDTH_W-1:0] width);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= width;
        @(posedge i_clk);
        width_setting = width;
        i_cfg_wr_en   <= 1'b0;
    endtask

    // reset width, field extremes and common audio rates
    task automatic test_corner_rates();
        logic [i2scrs_pkg::DATA_W-1:0] corners [14];
        corners = '{24'd0, 24'd1, 24'd2, 24'd1000, 24'd8000, 24'd11025, 24'd44100,
                    24'd48000, 24'd96000, 24'd192000, 24'd500000, 24'd8000000,
                    24'd16000000, 24'hFFFFFF};
        foreach (corners[i]) send_rate(corners[i]);
    endtask

    // every width, zero width included
    task automatic test_width_settings();
        logic [i2scrs_pkg::WIDTH_W-1:0] widths [4];
        widths = '{2'd0, 2'd3, 2'd1, 2'd2};
        foreach (widths[i]) begin
            wait_all_results();
            write_width(widths[i]);
            send_rate(24'd1);
            send_rate(24'd48000);
            send_rate(24'd16000000);
        end
    endtask

    task automatic test_random_rates(input logic [i2scrs_pkg::WIDTH_W-1:0] width,
                                     input int tx_pct, input int rx_pct, input int count);
        wait_all_results();
        write_width(width);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_rate(random_rate());
    endtask

    // hold the result side so the unit fills and stalls its input
    task automatic test_output_stall();
        wait_all_results();
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_cycles = 5000;
        repeat (4) send_rate(random_rate());
        wait_all_results();
        repeat (2) send_rate(random_rate());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_rates();
        test_width_settings();
        test_random_rates(2'd1, 7, 63, 115);
        test_random_rates(2'd3, 63, 7, 115);
        test_random_rates(2'd0, 0, 0, 60);
        test_random_rates(2'd2, 0, 0, 60);
        test_output_stall();
        wait_all_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (pending_choices.size() != 0) begin
            mismatches++;
            $display("%0t: pending results expected 0 actual %0d", $time,
                     pending_choices.size());
        end
        if (mismatches == 0) begin
            $display("i2s_clock_ratio_search_unit test passed");
        end else begin
            $display("i2s_clock_ratio_search_unit test failed");
        end
        $finish;
    end

endmodule
